[design/fsp_pkg.sv]
// fsp_pkg: shared types and constants for the format specifier parser.
// Character codes, token kinds, length letter codes and transaction structs.
// No dependencies.
package fsp_pkg;

   // Default saturation width of width and precision accumulators
   localparam int NumBitsDefault = 16;

   // Depth of the token and result queues
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LOW_H = 8'h68;
   localparam logic [7:0] CH_LOW_L = 8'h6C;
   localparam logic [7:0] CH_BIG_L = 8'h4C;
   localparam logic [7:0] CH_PCT   = 8'h25;

   // Flag bits
   localparam logic [4:0] FLAG_MINUS = 5'b00001;
   localparam logic [4:0] FLAG_PLUS  = 5'b00010;
   localparam logic [4:0] FLAG_SPACE = 5'b00100;
   localparam logic [4:0] FLAG_ALT   = 5'b01000;
   localparam logic [4:0] FLAG_ZPAD  = 5'b10000;
   localparam logic [4:0] FLAG_NONE  = 5'b00000;

   // Length mask bits
   localparam logic [4:0] LEN_H    = 5'b00001;
   localparam logic [4:0] LEN_HH   = 5'b00010;
   localparam logic [4:0] LEN_L    = 5'b00100;
   localparam logic [4:0] LEN_LL   = 5'b01000;
   localparam logic [4:0] LEN_BIGL = 5'b10000;
   localparam logic [4:0] LEN_NONE = 5'b00000;

   // Length letter codes
   typedef logic [1:0] letter_type;
   localparam letter_type LET_NONE = 2'd0;
   localparam letter_type LET_H    = 2'd1;
   localparam letter_type LET_L    = 2'd2;
   localparam letter_type LET_BIGL = 2'd3;

   // Token kinds
   typedef logic [2:0] kind_type;
   localparam kind_type TK_OTHER  = 3'd0;
   localparam kind_type TK_NUL    = 3'd1;
   localparam kind_type TK_PCT    = 3'd2;
   localparam kind_type TK_FLAG   = 3'd3;
   localparam kind_type TK_STAR   = 3'd4;
   localparam kind_type TK_DIGIT  = 3'd5;
   localparam kind_type TK_DOT    = 3'd6;
   localparam kind_type TK_LETTER = 3'd7;

   typedef struct packed {
      logic [7:0]         ch;
      logic signed [31:0] star_arg;
   } req_type;

   typedef struct packed {
      logic [7:0]  conv_char;
      logic [4:0]  flag_bits;
      logic [15:0] field_width;
      logic [15:0] prec_value;
      logic        prec_given;
      logic [4:0]  length_mask;
      logic        literal_percent;
   } rsp_type;

   // Classified character, as the back end consumes it
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ch;
      logic [3:0]  digit;
      logic [4:0]  flag_mask;   // nonzero also for the zero digit
      letter_type  letter;
      logic        star_neg;
      logic [31:0] star_mag;    // magnitude, already saturated
   } tok_type;

endpackage

[design/fsp_fifo.sv]
// fsp_fifo: small register queue used between the parser stages.
// Uses fsp_pkg for the queue depth.
module fsp_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] rdata
);
   import fsp_pkg::*;

   logic [DATA_W-1:0]    mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic                 push_ok, pop_ok;

   assign full    = (count_ff == QueueCntW'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[design/fsp_front.sv]
// fsp_front: accepts characters, classifies them and queues the tokens.
// Uses fsp_pkg and fsp_fifo.
module fsp_front #(
   parameter int NUM_BITS = fsp_pkg::NumBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fsp_pkg::req_type req_data,
   output logic             req_full,
   output logic             tok_valid,
   input  logic             tok_pop,
   output fsp_pkg::tok_type tok_data
);
   import fsp_pkg::*;

   localparam logic [32:0] NumMaxWide = (33'd1 << NUM_BITS) - 33'd1;
   localparam logic [31:0] NumMax     = NumMaxWide[31:0];

   tok_type     tok_new;
   logic [31:0] raw;
   logic [31:0] mag;
   logic        neg;
   logic        tok_empty;

   assign raw = req_data.star_arg;
   assign neg = raw[31];
   assign mag = neg ? (~raw + 32'd1) : raw;

   always_comb begin
      tok_new           = '0;
      tok_new.ch        = req_data.ch;
      tok_new.digit     = req_data.ch[3:0];
      tok_new.star_neg  = neg;
      tok_new.star_mag  = (mag > NumMax) ? NumMax : mag;
      tok_new.flag_mask = FLAG_NONE;
      tok_new.letter    = LET_NONE;
      tok_new.kind      = TK_OTHER;
      priority if (req_data.ch == CH_NUL) begin
         tok_new.kind = TK_NUL;
      end else if (req_data.ch == CH_PCT) begin
         tok_new.kind = TK_PCT;
      end else if (req_data.ch == CH_MINUS) begin
         tok_new.kind      = TK_FLAG;
         tok_new.flag_mask = FLAG_MINUS;
      end else if (req_data.ch == CH_PLUS) begin
         tok_new.kind      = TK_FLAG;
         tok_new.flag_mask = FLAG_PLUS;
      end else if (req_data.ch == CH_SPACE) begin
         tok_new.kind      = TK_FLAG;
         tok_new.flag_mask = FLAG_SPACE;
      end else if (req_data.ch == CH_HASH) begin
         tok_new.kind      = TK_FLAG;
         tok_new.flag_mask = FLAG_ALT;
      end else if (req_data.ch >= CH_ZERO && req_data.ch <= CH_NINE) begin
         tok_new.kind = TK_DIGIT;
         // zero acts as a flag while still in the flag phase
         if (req_data.ch == CH_ZERO) begin
            tok_new.flag_mask = FLAG_ZPAD;
         end
      end else if (req_data.ch == CH_STAR) begin
         tok_new.kind = TK_STAR;
      end else if (req_data.ch == CH_DOT) begin
         tok_new.kind = TK_DOT;
      end else if (req_data.ch == CH_LOW_H) begin
         tok_new.kind   = TK_LETTER;
         tok_new.letter = LET_H;
      end else if (req_data.ch == CH_LOW_L) begin
         tok_new.kind   = TK_LETTER;
         tok_new.letter = LET_L;
      end else if (req_data.ch == CH_BIG_L) begin
         tok_new.kind   = TK_LETTER;
         tok_new.letter = LET_BIGL;
      end else begin
         tok_new.kind = TK_OTHER;
      end
   end

   fsp_fifo #(
      .DATA_W ($bits(tok_type))
   ) u_tok_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (tok_new),
      .full  (req_full),
      .pop   (tok_pop),
      .empty (tok_empty),
      .rdata (tok_data)
   );

   assign tok_valid = !tok_empty;

endmodule

[design/fsp_back.sv]
// fsp_back: specifier state machine; consumes tokens, builds results.
// Uses fsp_pkg.
module fsp_back #(
   parameter int NUM_BITS = fsp_pkg::NumBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tok_valid,
   input  fsp_pkg::tok_type tok_data,
   output logic             tok_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output fsp_pkg::rsp_type rsp_data
);
   import fsp_pkg::*;

   localparam int AccW = NUM_BITS + 4;

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_FLAGS = 3'd1;
   localparam logic [2:0] PH_WSTAR = 3'd2;
   localparam logic [2:0] PH_WDIG  = 3'd3;
   localparam logic [2:0] PH_DOT   = 3'd4;
   localparam logic [2:0] PH_PSTAR = 3'd5;
   localparam logic [2:0] PH_PDIG  = 3'd6;
   localparam logic [2:0] PH_LEN   = 3'd7;

   logic [2:0]          phase_ff, phase_in;
   logic [4:0]          flags_ff, flags_in;
   logic [NUM_BITS-1:0] width_ff, width_in;
   logic [NUM_BITS-1:0] prec_ff, prec_in;
   logic                prec_seen_ff, prec_seen_in;
   logic [4:0]          len_ff, len_in;
   letter_type          pend_ff, pend_in;

   logic [2:0]          eff;
   logic                in_width, in_prec, consume, emit, lit;
   logic [NUM_BITS-1:0] acc_base, acc_next, star_val;
   logic [AccW-1:0]     acc_wide;
   logic [4:0]          single_len;
   logic [31:0]         width_ext, prec_ext;

   // acc*10 + digit, saturating
   assign acc_base = (eff == PH_WDIG) ? width_ff : (eff == PH_PDIG) ? prec_ff : '0;
   assign acc_wide = (AccW'(acc_base) << 3) + (AccW'(acc_base) << 1) + AccW'(tok_data.digit);
   assign acc_next = (acc_wide[AccW-1:NUM_BITS] != '0) ? '1 : acc_wide[NUM_BITS-1:0];
   assign star_val = tok_data.star_mag[NUM_BITS-1:0];

   assign eff      = (phase_ff == PH_START) ? PH_FLAGS : phase_ff;
   assign in_width = (eff == PH_FLAGS) || (eff == PH_WSTAR) || (eff == PH_WDIG);
   assign in_prec  = (eff == PH_DOT) || (eff == PH_PSTAR) || (eff == PH_PDIG);
   assign consume  = tok_valid && !rsp_full;
   assign tok_pop  = consume;
   assign rsp_push = consume && emit;

   assign single_len = ((pend_ff == LET_H) ? LEN_H : LEN_NONE)
                     | ((pend_ff == LET_L) ? LEN_L : LEN_NONE);

   always_comb begin
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      prec_seen_in = prec_seen_ff;
      len_in       = len_ff;
      pend_in      = pend_ff;
      emit         = 1'b0;
      lit          = 1'b0;
      priority if (phase_ff == PH_START && tok_data.kind == TK_PCT) begin
         emit = 1'b1;
         lit  = 1'b1;
      end else if (tok_data.kind == TK_NUL) begin
         emit = 1'b1;
      end else if (eff == PH_FLAGS && tok_data.flag_mask != FLAG_NONE) begin
         flags_in = flags_ff | tok_data.flag_mask;
         phase_in = PH_FLAGS;
      end else if (eff == PH_FLAGS && tok_data.kind == TK_STAR) begin
         if (tok_data.star_neg) begin
            flags_in = flags_ff | FLAG_MINUS;
         end
         width_in = star_val;
         phase_in = PH_WSTAR;
      end else if (tok_data.kind == TK_DIGIT && in_width) begin
         width_in = acc_next;
         phase_in = PH_WDIG;
      end else if (tok_data.kind == TK_DOT && in_width) begin
         prec_seen_in = 1'b1;
         phase_in     = PH_DOT;
      end else if (eff == PH_DOT && tok_data.kind == TK_STAR) begin
         if (tok_data.star_neg) begin
            prec_in      = '0;
            prec_seen_in = 1'b0;
         end else begin
            prec_in = star_val;
         end
         phase_in = PH_PSTAR;
      end else if (tok_data.kind == TK_DIGIT && in_prec) begin
         prec_in  = acc_next;
         phase_in = PH_PDIG;
      end else if (tok_data.kind == TK_LETTER) begin
         if (pend_ff != LET_NONE && pend_ff == tok_data.letter) begin
            len_in  = len_ff | ((tok_data.letter == LET_H) ? LEN_HH : LEN_LL);
            pend_in = LET_NONE;
         end else begin
            len_in  = len_ff | single_len
                    | ((tok_data.letter == LET_BIGL) ? LEN_BIGL : LEN_NONE);
            pend_in = tok_data.letter;
         end
         phase_in = PH_LEN;
      end else begin
         emit = 1'b1;
      end
      if (emit) begin
         phase_in     = PH_START;
         flags_in     = FLAG_NONE;
         width_in     = '0;
         prec_in      = '0;
         prec_seen_in = 1'b0;
         len_in       = LEN_NONE;
         pend_in      = LET_NONE;
      end
   end

   assign width_ext = 32'(width_ff);
   assign prec_ext  = 32'(prec_ff);

   always_comb begin
      rsp_data                 = '0;
      rsp_data.conv_char       = tok_data.ch;
      rsp_data.literal_percent = lit;
      if (!lit) begin
         rsp_data.flag_bits   = flags_ff;
         rsp_data.field_width = width_ext[15:0];
         rsp_data.prec_value  = prec_ext[15:0];
         rsp_data.prec_given  = prec_seen_ff;
         rsp_data.length_mask = len_ff | single_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         flags_ff     <= FLAG_NONE;
         width_ff     <= '0;
         prec_ff      <= '0;
         prec_seen_ff <= 1'b0;
         len_ff       <= LEN_NONE;
         pend_ff      <= LET_NONE;
      end else if (consume) begin
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         width_ff     <= width_in;
         prec_ff      <= prec_in;
         prec_seen_ff <= prec_seen_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

[design/format_spec_parser.sv]
// format_spec_parser: top level of the printf conversion specifier parser.
// Uses fsp_pkg, fsp_front, fsp_back and fsp_fifo.
//
// Feed the characters that follow a '%' one per transaction on req_data,
// with the integer a '*' would consume in star_arg. The parser walks flags,
// width ('*' or digits), precision after '.', and length letters (h, hh, l,
// ll, L, LL). The first character that does not fit ends the specifier and
// produces one result transaction holding flags, width, precision, length
// mask and that ending character; a '%' as the first character gives a
// literal percent result. Widths and precisions saturate at 2^NUM_BITS-1
// and are reported in 16 bits. Throughput is one character per clock while
// the result queue has room: the front end classifies each character into
// a two-entry token queue, and the back end state machine retires one token
// per cycle into a two-entry result queue. A result reaches rsp_data once
// the back end has popped its ending token and pushed the result into the
// result queue. While rsp_pop stays low, the result queue fills, the back
// end holds, and once the token queue also fills req_full rises. There is no
// clearing pass; the block is usable in the cycle after reset is released.
module format_spec_parser #(
   parameter int NUM_BITS = fsp_pkg::NumBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fsp_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fsp_pkg::rsp_type rsp_data
);
   import fsp_pkg::*;

   // token path: front -> back
   logic    tok_valid;
   logic    tok_pop;
   tok_type tok_data;

   // result path: back -> result queue
   logic    rsp_q_full;
   logic    rsp_q_push;
   rsp_type rsp_q_data;

   fsp_front #(
      .NUM_BITS (NUM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .tok_valid (tok_valid),
      .tok_pop   (tok_pop),
      .tok_data  (tok_data)
   );

   // back stalls only when the result queue is full
   fsp_back #(
      .NUM_BITS (NUM_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok_data  (tok_data),
      .tok_pop   (tok_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_q_push),
      .rsp_data  (rsp_q_data)
   );

   // result queue decouples the state machine from the consumer
   fsp_fifo #(
      .DATA_W ($bits(rsp_type))
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_q_push),
      .wdata (rsp_q_data),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_data)
   );

endmodule

[design/fsp_checker.sv]
// fsp_checker: port-level assertions for format_spec_parser, with bind.
// Uses fsp_pkg.
module fsp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input fsp_pkg::rsp_type rsp_data
);
   import fsp_pkg::*;

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a held result does not change or vanish
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result changed while waiting");

   // literal percent carries nothing but the percent sign
   a_literal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.literal_percent |->
         rsp_data.conv_char == CH_PCT && rsp_data.flag_bits == FLAG_NONE &&
         rsp_data.field_width == '0 && rsp_data.prec_value == '0 &&
         !rsp_data.prec_given && rsp_data.length_mask == LEN_NONE)
      else $error("literal percent with stray fields");

   // input side only fills up through a push
   a_full_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("req_full rose without a push");

   // results only leave through a pop
   a_empty_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("result dropped without a pop");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

[bench/format_spec_parser_tb.sv]
// format_spec_parser_tb: self-checking bench for the printf specifier parser.
// Depends on fsp_pkg and format_spec_parser; keeps its own model of the parser
// and checks every result transaction against it, field by field.
module format_spec_parser_tb;
   import fsp_pkg::*;

   // Saturation ceiling for widths and precisions at the default NUM_BITS
   localparam logic [31:0] SpecMax      = (32'd1 << NumBitsDefault) - 32'd1;
   localparam int unsigned RandomItems  = 1200;
   // A result trails its ending character through the token and result queues
   localparam int unsigned DrainCycles  = 8;
   // Cycles with no transaction on either side before the run is abandoned
   localparam int unsigned QuietLimit   = 2000;

   // Parser phases, as the bench tracks them
   typedef enum logic [2:0] {
      SP_START, SP_FLAGS, SP_WSTAR, SP_WDIG, SP_DOT, SP_PSTAR, SP_PDIG, SP_LEN
   } spec_phase_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_QUARTER, POP_TRICKLE} pop_mode_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   always #5 clock = ~clock;

   format_spec_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Specifier model: state mirrors what the parser has absorbed so far
   // ---------------------------------------------------------------------
   spec_phase_type spec_phase;
   logic [4:0]     spec_flags;
   logic [15:0]    spec_width;
   logic [15:0]    spec_prec;
   logic           spec_prec_seen;
   logic [4:0]     spec_len;
   letter_type     spec_pending;

   // Finished specifiers waiting for their result transaction, oldest first
   rsp_type     parsed_specs[$];

   int unsigned spec_errors = 0;
   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;

   logic [7:0]  flag_set[5]   = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO};
   logic [7:0]  letter_set[3] = '{CH_LOW_H, CH_LOW_L, CH_BIG_L};
   string       conv_set      = "diouxXfeEgcsp%n";

   function automatic void clear_spec();
      spec_phase     = SP_START;
      spec_flags     = FLAG_NONE;
      spec_width     = '0;
      spec_prec      = '0;
      spec_prec_seen = 1'b0;
      spec_len       = LEN_NONE;
      spec_pending   = LET_NONE;
   endfunction

   function automatic void record_spec(input logic [7:0] c, input logic lit);
      rsp_type r;
      r.conv_char       = c;
      r.flag_bits       = spec_flags;
      r.field_width     = spec_width;
      r.prec_value      = spec_prec;
      r.prec_given      = spec_prec_seen;
      r.length_mask     = spec_len;
      r.literal_percent = lit;
      parsed_specs.push_back(r);
   endfunction

   // Decimal accumulate, clamped at the ceiling
   function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
      int unsigned a;
      int unsigned v;
      a = acc;
      v = a * 10 + d;
      return (v > SpecMax) ? SpecMax[15:0] : v[15:0];
   endfunction

   function automatic logic [15:0] clamp_mag(input logic [31:0] m);
      return (m > SpecMax) ? SpecMax[15:0] : m[15:0];
   endfunction

   function automatic letter_type letter_of(input logic [7:0] c);
      if (c == CH_LOW_H) return LET_H;
      if (c == CH_LOW_L) return LET_L;
      if (c == CH_BIG_L) return LET_BIGL;
      return LET_NONE;
   endfunction

   // A lone h or l still waiting for a partner counts as a single letter
   function automatic void settle_letter();
      if (spec_pending == LET_H) spec_len |= LEN_H;
      if (spec_pending == LET_L) spec_len |= LEN_L;
      spec_pending = LET_NONE;
   endfunction

   // Advance the model by one accepted character
   function automatic void parse_char(input req_type item);
      logic [7:0]     c;
      logic [31:0]    raw;
      logic [31:0]    mag;
      logic           neg;
      logic           is_digit;
      logic [4:0]     flag;
      letter_type     letter;
      spec_phase_type ph;
      c        = item.ch;
      raw      = item.star_arg;
      neg      = raw[31];
      mag      = neg ? (~raw + 32'd1) : raw;   // most negative value stays 2^31
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      letter   = letter_of(c);
      ph       = spec_phase;

      if (ph == SP_START) begin
         // percent right after the opening percent: literal, all else zero
         if (c == CH_PCT) begin
            clear_spec();
            record_spec(c, 1'b1);
            return;
         end
         ph = SP_FLAGS;
      end

      if (c != CH_NUL) begin
         if (ph == SP_FLAGS) begin
            // '0' here is always the zero-pad flag, never a width digit
            case (c)
               CH_MINUS: flag = FLAG_MINUS;
               CH_PLUS:  flag = FLAG_PLUS;
               CH_SPACE: flag = FLAG_SPACE;
               CH_HASH:  flag = FLAG_ALT;
               CH_ZERO:  flag = FLAG_ZPAD;
               default:  flag = FLAG_NONE;
            endcase
            if (flag != FLAG_NONE) begin
               spec_flags |= flag;
               spec_phase  = SP_FLAGS;
               return;
            end
            if (c == CH_STAR) begin
               // negative width star means left-justify, magnitude used
               if (neg) spec_flags |= FLAG_MINUS;
               spec_width = clamp_mag(mag);
               spec_phase = SP_WSTAR;
               return;
            end
         end
         if (is_digit && (ph == SP_FLAGS || ph == SP_WSTAR || ph == SP_WDIG)) begin
            // digits after a star replace the star's value
            if (ph != SP_WDIG) spec_width = '0;
            spec_width = add_digit(spec_width, 4'(c - CH_ZERO));
            spec_phase = SP_WDIG;
            return;
         end
         if (c == CH_DOT && ph <= SP_WDIG) begin
            spec_prec_seen = 1'b1;
            spec_phase     = SP_DOT;
            return;
         end
         if (ph == SP_DOT && c == CH_STAR) begin
            // negative precision star acts as if no precision was given
            if (neg) begin
               spec_prec      = '0;
               spec_prec_seen = 1'b0;
            end else begin
               spec_prec = clamp_mag(mag);
            end
            spec_phase = SP_PSTAR;
            return;
         end
         if (is_digit && (ph == SP_DOT || ph == SP_PSTAR || ph == SP_PDIG)) begin
            if (ph != SP_PDIG) spec_prec = '0;
            spec_prec  = add_digit(spec_prec, 4'(c - CH_ZERO));
            spec_phase = SP_PDIG;
            return;
         end
         if (letter != LET_NONE) begin
            // hh and ll pair up; LL sets ll on top of the L from the first one
            if (spec_pending != LET_NONE && spec_pending == letter) begin
               spec_len    |= (letter == LET_H) ? LEN_HH : LEN_LL;
               spec_pending = LET_NONE;
            end else begin
               settle_letter();
               if (letter == LET_BIGL) spec_len |= LEN_BIGL;
               spec_pending = letter;
            end
            spec_phase = SP_LEN;
            return;
         end
      end

      // Anything else, including end of string, closes the specifier
      settle_letter();
      record_spec(c, 1'b0);
      clear_spec();
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         spec_errors++;
      end
   endfunction

   function automatic void check_spec(input rsp_type got);
      rsp_type want;
      if (parsed_specs.size() == 0) begin
         $error("result with none pending: conv_char %0h", got.conv_char);
         spec_errors++;
         return;
      end
      want = parsed_specs.pop_front();
      check_field("conv_char",       want.conv_char,       got.conv_char);
      check_field("flag_bits",       want.flag_bits,       got.flag_bits);
      check_field("field_width",     want.field_width,     got.field_width);
      check_field("prec_value",      want.prec_value,      got.prec_value);
      check_field("prec_given",      want.prec_given,      got.prec_given);
      check_field("length_mask",     want.length_mask,     got.length_mask);
      check_field("literal_percent", want.literal_percent, got.literal_percent);
   endfunction

   // Input side: every accepted character goes through the model
   always @(posedge clock) begin
      if (reset)
         clear_spec();
      else if (req_push && !req_full)
         parse_char(req_data);
   end

   // Output side: check the popped transaction, then pick the next pop.
   // The stall pattern is redrawn for each random-length segment so stalls
   // land on every phase of the parser's work, with stretches of no stall at all.
   pop_mode_type pop_mode = POP_ALWAYS;
   int unsigned  pop_seg  = 0;
   int unsigned  pop_tick = 0;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_spec(rsp_data);
      if (pop_seg == 0) begin
         pop_mode = pop_mode_type'($urandom_range(0, 3));
         pop_seg  = $urandom_range(20, 100);
      end else begin
         pop_seg--;
      end
      pop_tick++;
      case (pop_mode)
         POP_ALWAYS:  rsp_pop <= 1'b1;
         POP_COIN:    rsp_pop <= 1'($urandom_range(0, 1));
         POP_QUARTER: rsp_pop <= (pop_tick % 4 == 0);
         default:     rsp_pop <= (pop_tick % 24 == 0);
      endcase
   end

   // Watchdog: give up when neither side has moved for too long
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // One character per transaction. The sender runs in bursts; between most
   // bursts push drops for a random gap.
   task automatic put_item(input logic [7:0] c, input logic [31:0] arg);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data <= '{ch: c, star_arg: arg};
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   // Plain characters; the star argument is noise and must be ignored
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) put_item(s[i], $urandom);
   endtask

   // Digit run, now and then long enough to saturate
   task automatic send_digits(input bit lead_nonzero);
      int unsigned n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
         put_item(CH_ZERO + 8'((i == 0 && lead_nonzero) ? $urandom_range(1, 9)
                                                       : $urandom_range(0, 9)), $urandom);
   endtask

   // Star arguments biased toward signs, extremes and the saturation edge
   function automatic logic [31:0] star_value();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return $urandom_range(0, 100);
         2:       return 32'(-int'($urandom_range(1, 100)));
         3:       return 32'h8000_0000;
         4:       return 32'h7FFF_FFFF;
         default: return $urandom_range(65530, 65540);
      endcase
   endfunction

   // Doubled percent, and a percent that only closes a flag run
   task automatic test_literal_percent;
      put_item(CH_PCT, $urandom);
      send_text("-");
      put_item(CH_PCT, $urandom);
   endtask

   // All flags, most negative width star overridden by digits, negative
   // precision star followed by digits, LL, and a top-value ending byte
   task automatic test_flags_and_stars;
      send_text("-+ #0");
      put_item(CH_STAR, 32'h8000_0000);
      send_text("12.");
      put_item(CH_STAR, 32'hFFFF_FFFD);
      send_text("7LL");
      put_item(8'hFF, $urandom);
   endtask

   // Star and digit saturation, bare dot, ll, and a lone h closed by NUL
   task automatic test_saturation;
      put_item(CH_STAR, 32'h7FFF_FFFF);
      put_item(CH_DOT, $urandom);
      put_item(CH_STAR, 32'd70000);
      put_item(CH_LOW_H, $urandom);
      put_item(CH_NUL, $urandom);
      send_text("70000.lld");
   endtask

   // End of string as the very first character
   task automatic test_string_end;
      put_item(CH_NUL, $urandom);
   endtask

   // Mostly well-formed specifiers with random content; the rest is lone percent
   // signs and raw bytes that leave the parser mid-specifier or close it early.
   task automatic test_random;
      int unsigned start;
      int unsigned k;
      start = items_sent;
      while (items_sent - start < RandomItems) begin
         k = $urandom_range(0, 19);
         if (k < 4) begin
            repeat ($urandom_range(1, 6)) put_item(8'($urandom_range(0, 255)), $urandom);
         end else if (k == 4) begin
            put_item(CH_PCT, $urandom);
         end else begin
            repeat ($urandom_range(0, 3)) put_item(flag_set[$urandom_range(0, 4)], $urandom);
            case ($urandom_range(0, 3))
               1: put_item(CH_STAR, star_value());
               2: send_digits(1'b1);
               3: begin
                  put_item(CH_STAR, star_value());
                  send_digits(1'b0);
               end
               default: ;
            endcase
            case ($urandom_range(0, 4))
               1: put_item(CH_DOT, $urandom);
               2: begin
                  put_item(CH_DOT, $urandom);
                  put_item(CH_STAR, star_value());
               end
               3: begin
                  put_item(CH_DOT, $urandom);
                  send_digits(1'b0);
               end
               4: begin
                  put_item(CH_DOT, $urandom);
                  put_item(CH_STAR, star_value());
                  send_digits(1'b0);
               end
               default: ;
            endcase
            case ($urandom_range(0, 3))
               1: put_item(letter_set[$urandom_range(0, 2)], $urandom);
               2: begin
                  k = $urandom_range(0, 2);
                  put_item(letter_set[k], $urandom);
                  put_item(letter_set[k], $urandom);
               end
               3: repeat ($urandom_range(1, 3))
                     put_item(letter_set[$urandom_range(0, 2)], $urandom);
               default: ;
            endcase
            k = $urandom_range(0, 9);
            if (k == 0)
               put_item(CH_NUL, $urandom);
            else if (k == 1)
               put_item(8'($urandom_range(0, 255)), $urandom);
            else
               put_item(conv_set[$urandom_range(0, conv_set.len() - 1)], $urandom);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_literal_percent;
      test_flags_and_stars;
      test_saturation;
      test_string_end;
      test_random;

      req_push <= 1'b0;
      // wait out every pending result; the watchdog bounds this
      while (parsed_specs.size() != 0) @(posedge clock);
      // catch any stray result trailing behind the last one
      repeat (DrainCycles) @(posedge clock);

      if (spec_errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
design/fsp_pkg.sv
design/fsp_fifo.sv
design/fsp_front.sv
design/fsp_back.sv
design/format_spec_parser.sv
design/fsp_checker.sv
bench/format_spec_parser_tb.sv
